[rtl/hhfs_pkg.sv]
// Package for the HTTP header field splitter.
// Holds the result kinds, character codes, limits and the phase and result types.
// No dependencies.
`default_nettype none

package hhfs_pkg;

  // Limits of the entry table, the held carriage return count and the result slots.
  localparam int unsigned MaxEntries   = 128;
  localparam int unsigned MaxPendingCr = 16;
  localparam int unsigned MaxSlots     = 3;

  localparam int unsigned EntryW = 8;
  localparam int unsigned IndexW = 7;
  localparam int unsigned CrW    = 5;
  localparam int unsigned SlotW  = 2;

  // Result kinds.
  localparam logic [2:0] KIND_NAME     = 3'd0;
  localparam logic [2:0] KIND_VALUE    = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_DISCARD  = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_NAME_EMPTY = 6'b000001,
    PH_NAME       = 6'b000010,
    PH_SKIP       = 6'b000100,
    PH_VALUE      = 6'b001000,
    PH_NEWLINE    = 6'b010000,
    PH_ERROR      = 6'b100000
  } phase_t;

  // One result beat without its end-of-run mark.
  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        data;
    logic [IndexW-1:0] index;
  } result_t;

endpackage

`default_nettype wire

[rtl/http_header_field_splitter.sv]
// HTTP header field splitter: tags header bytes as name or value bytes.
// Depends on hhfs_pkg for the result kinds, character codes and types.
//
// Usage: the input channel (in_valid, in_stall, data_byte, last_byte) takes one
// header byte per beat; last_byte marks the final byte of a header block. The
// output channel (out_valid, out_stall, kind, out_byte, entry_index,
// last_of_run) gives the results each byte causes, one per beat, with
// last_of_run set on the final result of a byte. A byte may cause no result.
// The accepting edge loads the byte's results into a descriptor, and from
// there each result moves into the output register in turn.
// Throughput: one result per cycle while out_stall does not hold a beat. The
// next byte is taken at the edge that moves the last result of the previous
// byte out, so the input stalls while a byte with several results drains.
// Input is taken every cycle as long as each byte yields at most one result
// and out_stall does not hold a beat; a byte yields at most 16 released
// carriage returns plus up to three other results. A byte with no result
// does not stall the input.
// Reset (rst, synchronous) empties the descriptor and output register and
// returns the parser to the start of a block. While out_stall holds a beat
// the beat stays unchanged and the descriptor drains no further.
`default_nettype none

module http_header_field_splitter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [2:0] kind,
  output      logic [7:0] out_byte,
  output      logic [6:0] entry_index,
  output      logic       last_of_run
);
  import hhfs_pkg::*;

  // Parser state.
  phase_t            phase, phase_next;
  logic [CrW-1:0]    cr_count, cr_count_next;
  logic [EntryW-1:0] entry_count, entry_count_next;

  // Result descriptor: released carriage returns first, then the slots.
  logic [CrW-1:0]    desc_cr;
  logic [IndexW-1:0] desc_cr_index;
  logic [SlotW-1:0]  desc_n;
  result_t           desc_slot [MaxSlots];

  // Decoded descriptor for the incoming byte.
  logic [CrW-1:0]    flush_next;
  logic [SlotW-1:0]  n_next;
  result_t           slot_next [MaxSlots];

  logic is_ws;
  logic do_cont;
  logic do_complete;
  logic do_name;
  logic do_value;
  logic desc_any;
  logic desc_final;
  logic pop;
  logic in_accept;
  result_t head;

  assign is_ws = (data_byte == CH_SPACE) || (data_byte == CH_TAB);

  // Decide which actions the byte triggers in the current phase.
  always_comb begin
    do_cont     = 1'b0;
    do_complete = 1'b0;
    do_name     = 1'b0;
    do_value    = 1'b0;
    unique case (phase)
      PH_NAME_EMPTY, PH_NAME: do_name = 1'b1;
      PH_SKIP:                do_value = !is_ws;
      PH_VALUE:               do_value = 1'b1;
      PH_NEWLINE: begin
        do_cont     = is_ws;
        do_complete = !is_ws;
        do_name     = !is_ws;
      end
      PH_ERROR: ;
      default: ;
    endcase
  end

  // Apply the actions in order, collecting results and the next state.
  always_comb begin
    phase_next       = phase;
    cr_count_next    = cr_count;
    entry_count_next = entry_count;
    flush_next       = '0;
    n_next           = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      slot_next[i] = '0;
    end

    // Continuation line: release held CRs, keep the newline and this byte.
    if (do_cont) begin
      flush_next = cr_count_next;
      cr_count_next = '0;
      slot_next[n_next] = '{KIND_VALUE, CH_LF, entry_count_next[IndexW-1:0]};
      n_next = n_next + SlotW'(1);
      slot_next[n_next] = '{KIND_VALUE, data_byte, entry_count_next[IndexW-1:0]};
      n_next = n_next + SlotW'(1);
      phase_next = PH_VALUE;
    end

    // Held newline ends the entry.
    if (do_complete) begin
      slot_next[n_next] = '{KIND_COMPLETE, 8'h00, entry_count_next[IndexW-1:0]};
      n_next = n_next + SlotW'(1);
      if (entry_count_next < EntryW'(MaxEntries)) begin
        entry_count_next = entry_count_next + EntryW'(1);
      end
      cr_count_next = '0;
      phase_next = PH_NAME_EMPTY;
    end

    // Field name byte or the colon that ends the name.
    if (do_name) begin
      if (data_byte == CH_COLON) begin
        if (entry_count_next >= EntryW'(MaxEntries)) begin
          slot_next[n_next] = '{KIND_OVERFLOW, 8'h00, '0};
          n_next = n_next + SlotW'(1);
          phase_next = PH_ERROR;
        end else begin
          phase_next = PH_SKIP;
        end
      end else begin
        slot_next[n_next] = '{KIND_NAME, data_byte, entry_count_next[IndexW-1:0]};
        n_next = n_next + SlotW'(1);
        phase_next = PH_NAME;
      end
    end

    // Field value byte: CRs are held up to MaxPendingCr, a newline is held, others go out.
    if (do_value) begin
      if (data_byte == CH_CR) begin
        if (cr_count_next >= CrW'(MaxPendingCr)) begin
          slot_next[n_next] = '{KIND_VALUE, CH_CR, entry_count_next[IndexW-1:0]};
          n_next = n_next + SlotW'(1);
        end else begin
          cr_count_next = cr_count_next + CrW'(1);
        end
        phase_next = PH_VALUE;
      end else if (data_byte == CH_LF) begin
        phase_next = PH_NEWLINE;
      end else begin
        flush_next = cr_count_next;
        cr_count_next = '0;
        slot_next[n_next] = '{KIND_VALUE, data_byte, entry_count_next[IndexW-1:0]};
        n_next = n_next + SlotW'(1);
        phase_next = PH_VALUE;
      end
    end

    // End of block: close what is open and start over.
    if (last_byte) begin
      if (phase_next == PH_NAME) begin
        slot_next[n_next] = '{KIND_DISCARD, 8'h00, entry_count_next[IndexW-1:0]};
        n_next = n_next + SlotW'(1);
      end else if ((phase_next == PH_SKIP) || (phase_next == PH_VALUE) ||
                   (phase_next == PH_NEWLINE)) begin
        slot_next[n_next] = '{KIND_COMPLETE, 8'h00, entry_count_next[IndexW-1:0]};
        n_next = n_next + SlotW'(1);
      end
      phase_next       = PH_NAME_EMPTY;
      cr_count_next    = '0;
      entry_count_next = '0;
    end
  end

  // Drain control: one descriptor entry per cycle into the output register unless out_stall holds a beat.
  assign desc_any   = (desc_cr != '0) || (desc_n != '0);
  assign desc_final = ((desc_cr == CrW'(1)) && (desc_n == '0)) ||
                      ((desc_cr == '0) && (desc_n == SlotW'(1)));
  assign pop        = desc_any && (!out_valid || !out_stall);
  assign in_stall   = desc_any && !(pop && desc_final);
  assign in_accept  = in_valid && !in_stall;

  // Next result to leave the descriptor.
  always_comb begin
    if (desc_cr != '0) begin
      head = '{KIND_VALUE, CH_CR, desc_cr_index};
    end else begin
      head = desc_slot[0];
    end
  end

  // Parser state and descriptor control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NAME_EMPTY;
      cr_count    <= '0;
      entry_count <= '0;
      desc_cr     <= '0;
      desc_n      <= '0;
    end else if (in_accept) begin
      phase       <= phase_next;
      cr_count    <= cr_count_next;
      entry_count <= entry_count_next;
      desc_cr     <= flush_next;
      desc_n      <= n_next;
    end else if (pop) begin
      if (desc_cr != '0) begin
        desc_cr <= desc_cr - CrW'(1);
      end else begin
        desc_n <= desc_n - SlotW'(1);
      end
    end
  end

  // Descriptor payload: load on accept, shift slots as they drain.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      desc_cr_index <= entry_count[IndexW-1:0];
      for (int i = 0; i < MaxSlots; i++) begin
        desc_slot[i] <= slot_next[i];
      end
    end else if (pop && (desc_cr == '0)) begin
      for (int i = 0; i < MaxSlots - 1; i++) begin
        desc_slot[i] <= desc_slot[i+1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind        <= head.kind;
      out_byte    <= head.data;
      entry_index <= head.index;
      last_of_run <= desc_final;
    end
  end

endmodule

`default_nettype wire

[tb/hhfs_tag_checker.sv]
// Checker for the HTTP header field splitter: watches both channels, predicts
// the tagged result beats of every accepted header byte and compares them.
// Depends on hhfs_pkg for the result kinds, character codes, limits and phases.
module hhfs_tag_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] kind,
  input  logic [7:0] out_byte,
  input  logic [6:0] entry_index,
  input  logic       last_of_run,
  output int         fail_count,
  output int         outstanding,
  output int         checked,
  output int         entries_done,
  output int         discards,
  output int         overflows
);
  import hhfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One tagged result beat as it appears on the output channel.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [6:0] index;
    logic       last;
  } tag_beat_t;

  // Parser state of the prediction.
  phase_t     ph;
  logic [4:0] cr_held;
  logic [7:0] entries;

  // Beats of the byte being split, and beats still due on the output.
  tag_beat_t  run_q[$];
  tag_beat_t  due_tags[$];
  tag_beat_t  got;
  tag_beat_t  want;

  task automatic put_tag(input logic [2:0] k, input logic [7:0] d, input logic [6:0] idx);
    run_q.push_back({k, d, idx, 1'b0});
  endtask

  // Held carriage returns go out as value bytes.
  task automatic release_crs();
    int i;
    for (i = 0; i < cr_held; i++) put_tag(KIND_VALUE, CH_CR, entries[6:0]);
    cr_held = '0;
  endtask

  task automatic close_entry();
    put_tag(KIND_COMPLETE, 8'h00, entries[6:0]);
    if (entries < MaxEntries) entries = entries + 8'd1;
    cr_held = '0;
    ph = PH_NAME_EMPTY;
  endtask

  task automatic take_name_char(input logic [7:0] b);
    if (b == CH_COLON) begin
      if (entries >= MaxEntries) begin
        put_tag(KIND_OVERFLOW, 8'h00, 7'd0);
        ph = PH_ERROR;
      end else begin
        ph = PH_SKIP;
      end
    end else begin
      put_tag(KIND_NAME, b, entries[6:0]);
      ph = PH_NAME;
    end
  endtask

  // Carriage returns are held back up to the limit, a newline waits for the next byte.
  task automatic take_value_char(input logic [7:0] b);
    if (b == CH_CR) begin
      if (cr_held >= MaxPendingCr) put_tag(KIND_VALUE, CH_CR, entries[6:0]);
      else cr_held = cr_held + 5'd1;
      ph = PH_VALUE;
    end else if (b == CH_LF) begin
      ph = PH_NEWLINE;
    end else begin
      release_crs();
      put_tag(KIND_VALUE, b, entries[6:0]);
      ph = PH_VALUE;
    end
  endtask

  // Works out every beat that one header byte causes and queues them.
  task automatic split_byte(input logic [7:0] b, input logic fin);
    run_q.delete();
    case (ph)
      PH_NAME_EMPTY, PH_NAME: take_name_char(b);
      PH_SKIP: if (b != CH_SPACE && b != CH_TAB) take_value_char(b);
      PH_VALUE: take_value_char(b);
      PH_NEWLINE: begin
        if (b == CH_SPACE || b == CH_TAB) begin
          release_crs();
          put_tag(KIND_VALUE, CH_LF, entries[6:0]);
          put_tag(KIND_VALUE, b, entries[6:0]);
          ph = PH_VALUE;
        end else begin
          close_entry();
          take_name_char(b);
        end
      end
      default: ;
    endcase
    // The end of a block closes what is open and starts over.
    if (fin) begin
      case (ph)
        PH_NAME: put_tag(KIND_DISCARD, 8'h00, entries[6:0]);
        PH_SKIP, PH_VALUE, PH_NEWLINE: close_entry();
        default: ;
      endcase
      ph = PH_NAME_EMPTY;
      cr_held = '0;
      entries = '0;
    end
    if (run_q.size() != 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) due_tags.push_back(run_q[i]);
  endtask

  // Predict on each accepted input beat, compare each accepted output beat.
  always @(posedge clk) begin
    if (rst) begin
      ph = PH_NAME_EMPTY;
      cr_held = '0;
      entries = '0;
      due_tags.delete();
      fail_count = 0;
      checked = 0;
      entries_done = 0;
      discards = 0;
      overflows = 0;
    end else begin
      if (in_valid && !in_stall) split_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        got = {kind, out_byte, entry_index, last_of_run};
        checked++;
        if (due_tags.size() == 0) begin
          fail_count++;
          $display("%0t: beat with nothing expected: kind %0d byte %02h index %0d last %0b",
                   $time, got.kind, got.data, got.index, got.last);
        end else begin
          want = due_tags.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected kind %0d byte %02h index %0d last %0b", $time,
                     want.kind, want.data, want.index, want.last);
            $display("%0t: actual   kind %0d byte %02h index %0d last %0b", $time,
                     got.kind, got.data, got.index, got.last);
          end
        end
        case (got.kind)
          KIND_COMPLETE: entries_done++;
          KIND_DISCARD:  discards++;
          KIND_OVERFLOW: overflows++;
          default: ;
        endcase
      end
    end
    outstanding <= due_tags.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the testbench for the HTTP header field splitter: clock, reset,
// header block stimulus, output stalls and the verdict.
// Depends on hhfs_pkg, http_header_field_splitter and hhfs_tag_checker.
module tb_top;
  import hhfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 300000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [6:0] entry_index;
  logic       last_of_run;

  int fail_count, outstanding, checked, entries_done, discards, overflows;

  // Stimulus control shared with the receiver process.
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;
  int   bytes_sent = 0;
  int   blocks_sent = 0;
  int   rand_bytes = 0;
  int   blk_no = 0;

  logic [7:0] blk_q[$];

  always #5 clk = ~clk;

  http_header_field_splitter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .out_byte(out_byte), .entry_index(entry_index),
    .last_of_run(last_of_run)
  );

  hhfs_tag_checker tag_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .out_byte(out_byte), .entry_index(entry_index),
    .last_of_run(last_of_run),
    .fail_count(fail_count), .outstanding(outstanding), .checked(checked),
    .entries_done(entries_done), .discards(discards), .overflows(overflows)
  );

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while quiet.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 150;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 34);
    end
  end

  // Offers one byte, with random idle cycles first, and waits for its beat.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_block();
    foreach (blk_q[i]) send_byte(blk_q[i], i == blk_q.size() - 1);
    blocks_sent++;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) blk_q.push_back(s[i]);
  endtask

  // A header block of well-formed entries with random content, or noise.
  task automatic make_block();
    int n_entries, len, sel;
    logic [7:0] c;
    blk_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) blk_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_entries = $urandom_range(1, 4);
      for (int e = 0; e < n_entries; e++) begin
        len = $urandom_range(0, 4);
        repeat (len) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
          blk_q.push_back(c);
        end
        blk_q.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) blk_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        len = $urandom_range(0, 5);
        repeat (len) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            // A run of carriage returns, now and then past the hold limit.
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(15, 19) : $urandom_range(1, 3))
              blk_q.push_back(CH_CR);
          end else if (sel == 1) begin
            blk_q.push_back(CH_LF);
            blk_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          end else begin
            blk_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        // The last entry may stop in its value.
        if (e != n_entries - 1 || $urandom_range(0, 2) != 0) begin
          sel = $urandom_range(0, 2);
          if (sel == 0) add_text("\r\n");
          else if (sel == 1) add_text("\n");
          else add_text("\r\r\n");
        end
      end
      // Sometimes trailing text without a colon.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_COLON || c == CH_SPACE || c == CH_TAB);
          blk_q.push_back(c);
        end
      end
    end
  endtask

  // A full entry table, a name byte past it, the colon that overflows it,
  // and bytes that are then ignored.
  task automatic make_dense_block();
    blk_q.delete();
    repeat (MaxEntries) begin
      if ($urandom_range(0, 1)) blk_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      blk_q.push_back(CH_COLON);
      blk_q.push_back(CH_LF);
    end
    blk_q.push_back(8'h5a);
    blk_q.push_back(CH_COLON);
    repeat (3) blk_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed blocks: byte extremes in a name, skipped blanks, released and
    // dropped carriage returns, continuations, a colon as the last byte,
    // discarded trailing text and a block ending on a newline.
    blk_q.delete();
    blk_q.push_back(8'h00);
    blk_q.push_back(8'hff);
    add_text(": \tv\rw\r\n c\r\nN:x\r\r");
    send_block();
    blk_q.delete();
    add_text(":");
    send_block();
    blk_q.delete();
    add_text("qz");
    send_block();
    blk_q.delete();
    add_text("a:b\n\t\n");
    send_block();

    // Random blocks; the receiver holds off during the first one.
    while (rand_bytes < 130) begin
      hold_req <= (blk_no == 0);
      quiet <= (blk_no >= 2 && blk_no < 5);
      if (blk_no == 1) begin
        make_dense_block();
      end else begin
        make_block();
        rand_bytes += blk_q.size();
      end
      send_block();
      blk_no++;
    end
    quiet <= 1'b0;
    in_valid <= 1'b0;

    // Drain, then leave time for any stray beat.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d header blocks, checked %0d result beats.",
             bytes_sent, blocks_sent, checked);
    $display("Seen %0d completed entries, %0d discarded tails, %0d table overflows.",
             entries_done, discards, overflows);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
